/* rtl/core/rpnc_pkg.sv */
// Shared constants and types for the near-center pixel removal block.
`timescale 1ns / 1ps
package rpnc_pkg;

  localparam int ROW_W       = 64;   // bits in one mask row
  localparam int MAX_DIM_DEF = 64;   // default largest mask side
  localparam int DIST_W      = 13;   // squared distance, threshold and rank width
  localparam int DIM_W       = 7;    // width and height register width
  localparam int CTR_W       = 6;    // center coordinate width
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int DIST_MAX    = 7938; // largest possible squared distance

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REMOVE_COUNT = 3'd4;

  // Per-column lane results for one row
  typedef struct packed {
    logic [ROW_W-1:0] near;  // set, in range, distance below the compare value
    logic [ROW_W-1:0] keep;  // set, in range, distance at or above it
  } lane_out_t;

endpackage

/* rtl/core/rpnc_if.sv */
// Channel interfaces: row input, result output and register writes.
`timescale 1ns / 1ps
interface rpnc_in_if;
  logic                     valid;
  logic                     ready;
  logic [rpnc_pkg::ROW_W-1:0] row_pixels;
  modport source (output valid, output row_pixels, input ready);
  modport sink   (input valid, input row_pixels, output ready);
endinterface

interface rpnc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpnc_pkg::ROW_W-1:0]  out_row_pixels;
  logic [rpnc_pkg::DIST_W-1:0] threshold_sq;
  logic                        last_row;
  modport source (output valid, output out_row_pixels, output threshold_sq,
                  output last_row, input ready);
  modport sink   (input valid, input out_row_pixels, input threshold_sq,
                  input last_row, output ready);
endinterface

interface rpnc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rpnc_pkg::CFG_IDX_W-1:0]  index;
  logic [rpnc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/rpnc_lanes.sv */
// Column lanes: squared distance of each pixel in a row against a compare value.
`timescale 1ns / 1ps
module rpnc_lanes #(
  parameter int MAX_DIM = rpnc_pkg::MAX_DIM_DEF
) (
  input  logic [rpnc_pkg::ROW_W-1:0]  row_bits,
  input  logic [$clog2(MAX_DIM)-1:0]  row_idx,
  input  logic [rpnc_pkg::DIM_W-1:0]  width_eff,
  input  logic [rpnc_pkg::CTR_W-1:0]  center_col,
  input  logic [rpnc_pkg::CTR_W-1:0]  center_row,
  input  logic [rpnc_pkg::DIST_W-1:0] cmp_val,
  output rpnc_pkg::lane_out_t         lanes
);

  localparam int SQ_W = 2 * rpnc_pkg::CTR_W;

  logic signed [rpnc_pkg::CTR_W:0] dy;
  logic [rpnc_pkg::CTR_W-1:0]      ady;
  logic [SQ_W-1:0]                 dy_sq;

  // Row term shared by all lanes
  always_comb begin
    dy    = $signed({1'b0, rpnc_pkg::CTR_W'(row_idx)}) - $signed({1'b0, center_row});
    ady   = dy[rpnc_pkg::CTR_W] ? rpnc_pkg::CTR_W'(-dy) : rpnc_pkg::CTR_W'(dy);
    dy_sq = ady * ady;
  end

  for (genvar c = 0; c < rpnc_pkg::ROW_W; c++) begin : g_lane
    if (c < MAX_DIM) begin : g_on
      logic signed [rpnc_pkg::CTR_W:0] dx;
      logic [rpnc_pkg::CTR_W-1:0]      adx;
      logic [SQ_W-1:0]                 dx_sq;
      logic [rpnc_pkg::DIST_W-1:0]     sq_d;
      logic                            live;
      logic                            is_near;

      always_comb begin
        dx      = $signed((rpnc_pkg::CTR_W+1)'(c)) - $signed({1'b0, center_col});
        adx     = dx[rpnc_pkg::CTR_W] ? rpnc_pkg::CTR_W'(-dx) : rpnc_pkg::CTR_W'(dx);
        dx_sq   = adx * adx;
        sq_d    = rpnc_pkg::DIST_W'(dx_sq) + rpnc_pkg::DIST_W'(dy_sq);
        live    = row_bits[c] && (rpnc_pkg::DIM_W'(c) < width_eff);
        is_near = sq_d < cmp_val;
      end

      assign lanes.near[c] = live && is_near;
      assign lanes.keep[c] = live && !is_near;
    end else begin : g_off
      assign lanes.near[c] = 1'b0;
      assign lanes.keep[c] = 1'b0;
    end
  end

endmodule

/* rtl/core/rpnc_count.sv */
// Merge stage: registers the lane hits, counts them and accumulates over a pass.
`timescale 1ns / 1ps
module rpnc_count #(
  parameter int MAX_DIM = rpnc_pkg::MAX_DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clr,
  input  logic                                   hit_valid,
  input  logic [rpnc_pkg::ROW_W-1:0]             hit,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]   cnt,
  output logic                                   busy
);

  localparam int CNT_W = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int POP_W = $clog2(MAX_DIM+1);

  logic [rpnc_pkg::ROW_W-1:0] hit_q;
  logic                       hit_q_valid;
  logic [POP_W-1:0]           pop;

  // Count the hits of one row
  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      pop = pop + POP_W'(hit_q[i]);
    end
  end

  // Hold the row hits, then accumulate
  always_ff @(posedge clk) begin
    hit_q <= hit;
    if (rst) begin
      hit_q_valid <= 1'b0;
      cnt         <= '0;
    end else begin
      hit_q_valid <= hit_valid;
      if (clr) begin
        cnt <= '0;
      end else if (hit_q_valid) begin
        cnt <= cnt + CNT_W'(pop);
      end
    end
  end

  assign busy = hit_q_valid;

endmodule

/* rtl/core/remove_pixels_nearest_center_top.sv */
// Top level: mask store, threshold search sequencer and result output.
//
// Channels: row_ch takes one mask row per transfer, result_ch gives one row
// per transfer with the threshold and a last-row flag, cfg_ch writes the
// five registers (index 0 width, 1 height, 2 center column, 3 center row,
// 4 remove count) and is always ready.
// Operation: rows load at one per cycle. When the configured height has
// arrived, the threshold is found bit by bit over 13 passes, each pass
// reading every stored row once through the column lanes and the counter.
// Each row is then read again, cleared and presented; the next row is read
// only after the receiver has taken the current one. The single read port
// of the mask store sets the pass length. Row input is held off from the
// last loaded row until the final result row has transferred.
// Reset: registers return to width 64, height 64, center 0, remove count
// 0; the load count clears. A stalled result holds in the output register.
`timescale 1ns / 1ps
module remove_pixels_nearest_center_top #(
  parameter int MAX_DIM = rpnc_pkg::MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rpnc_in_if.sink    row_ch,
  rpnc_out_if.source result_ch,
  rpnc_cfg_if.sink   cfg_ch
);

  localparam int AW    = $clog2(MAX_DIM);
  localparam int RL_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int CMP_W = (CNT_W > rpnc_pkg::DIST_W) ? CNT_W : rpnc_pkg::DIST_W;
  localparam int BP_W  = $clog2(rpnc_pkg::DIST_W);
  localparam logic [rpnc_pkg::DIM_W-1:0] DIM_MAX = rpnc_pkg::DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {S_LOAD, S_SEARCH, S_EMIT} state_t;

  // Configuration registers
  logic [rpnc_pkg::DIM_W-1:0]  mask_width;
  logic [rpnc_pkg::DIM_W-1:0]  mask_height;
  logic [rpnc_pkg::CTR_W-1:0]  center_col;
  logic [rpnc_pkg::CTR_W-1:0]  center_row;
  logic [rpnc_pkg::DIST_W-1:0] remove_count;

  // Sequencer state
  state_t                      state;
  logic [RL_W-1:0]             rows_loaded;
  logic [RL_W-1:0]             rows_loaded_next;
  logic [AW-1:0]               addr;
  logic [AW-1:0]               row1;
  logic                        iss;
  logic                        v1;
  logic                        e_iss;
  logic                        e_v;
  logic [BP_W-1:0]             bitpos;
  logic [rpnc_pkg::DIST_W-1:0] x;
  logic [rpnc_pkg::DIST_W-1:0] thr;

  // Result register
  logic                        out_valid;
  logic [rpnc_pkg::ROW_W-1:0]  out_row;
  logic [rpnc_pkg::DIST_W-1:0] out_thr;
  logic                        out_last;

  // Mask store
  logic [rpnc_pkg::ROW_W-1:0]  mem [MAX_DIM];
  logic [rpnc_pkg::ROW_W-1:0]  mem_q;

  logic [rpnc_pkg::DIM_W-1:0]  width_eff;
  logic [rpnc_pkg::DIM_W-1:0]  height_eff;
  logic [rpnc_pkg::DIST_W-1:0] t_try;
  logic [rpnc_pkg::DIST_W-1:0] cmp_val;
  logic [rpnc_pkg::DIST_W-1:0] rank;
  logic [rpnc_pkg::DIST_W-1:0] x_final;
  logic                        take;
  logic                        last_addr;
  logic                        in_xfer;
  logic                        out_xfer;
  logic                        pass_done;
  logic                        cnt_clr;
  logic [CNT_W-1:0]            cnt;
  logic                        cnt_busy;
  rpnc_pkg::lane_out_t         lanes;

  // Register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width   <= rpnc_pkg::DIM_W'(64);
      mask_height  <= rpnc_pkg::DIM_W'(64);
      center_col   <= '0;
      center_row   <= '0;
      remove_count <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rpnc_pkg::REG_MASK_WIDTH:   mask_width   <= rpnc_pkg::DIM_W'(cfg_ch.data);
        rpnc_pkg::REG_MASK_HEIGHT:  mask_height  <= rpnc_pkg::DIM_W'(cfg_ch.data);
        rpnc_pkg::REG_CENTER_COL:   center_col   <= rpnc_pkg::CTR_W'(cfg_ch.data);
        rpnc_pkg::REG_CENTER_ROW:   center_row   <= rpnc_pkg::CTR_W'(cfg_ch.data);
        rpnc_pkg::REG_REMOVE_COUNT: remove_count <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Saturate the dimensions; a zero height counts as one row
  always_comb begin
    width_eff  = (mask_width > DIM_MAX) ? DIM_MAX : mask_width;
    if (mask_height == '0) begin
      height_eff = rpnc_pkg::DIM_W'(1);
    end else begin
      height_eff = (mask_height > DIM_MAX) ? DIM_MAX : mask_height;
    end
  end

  // Search and handshake decode
  always_comb begin
    in_xfer          = row_ch.valid && row_ch.ready;
    out_xfer         = out_valid && result_ch.ready;
    rows_loaded_next = rows_loaded + RL_W'(1);
    last_addr        = rpnc_pkg::DIM_W'(addr) == height_eff - rpnc_pkg::DIM_W'(1);
    t_try            = x | (rpnc_pkg::DIST_W'(1) << bitpos);
    rank             = (remove_count == '0) ? rpnc_pkg::DIST_W'(1) : remove_count;
    take             = CMP_W'(cnt) < CMP_W'(rank);
    x_final          = take ? t_try : x;
    pass_done        = (state == S_SEARCH) && !iss && !v1 && !cnt_busy;
    cnt_clr          = pass_done;
    cmp_val          = (state == S_SEARCH) ? t_try : thr;
  end

  // Mask store write and registered read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[rows_loaded[AW-1:0]] <= row_ch.row_pixels;
    end
    mem_q <= mem[addr];
    row1  <= addr;
  end

  rpnc_lanes #(.MAX_DIM(MAX_DIM)) u_lanes (
    .row_bits   (mem_q),
    .row_idx    (row1),
    .width_eff  (width_eff),
    .center_col (center_col),
    .center_row (center_row),
    .cmp_val    (cmp_val),
    .lanes      (lanes)
  );

  rpnc_count #(.MAX_DIM(MAX_DIM)) u_count (
    .clk       (clk),
    .rst       (rst),
    .clr       (cnt_clr),
    .hit_valid (v1),
    .hit       (lanes.near),
    .cnt       (cnt),
    .busy      (cnt_busy)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      rows_loaded <= '0;
      addr        <= '0;
      iss         <= 1'b0;
      v1          <= 1'b0;
      e_iss       <= 1'b0;
      e_v         <= 1'b0;
      bitpos      <= '0;
      x           <= '0;
      thr         <= '0;
      out_valid   <= 1'b0;
    end else begin
      v1 <= (state == S_SEARCH) && iss;
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (rpnc_pkg::DIM_W'(rows_loaded_next) >= height_eff) begin
              rows_loaded <= '0;
              state       <= S_SEARCH;
              bitpos      <= BP_W'(rpnc_pkg::DIST_W - 1);
              x           <= '0;
              addr        <= '0;
              iss         <= 1'b1;
            end else begin
              rows_loaded <= rows_loaded_next;
            end
          end
        end
        S_SEARCH: begin
          // Sweep the stored rows, then settle one threshold bit
          if (iss) begin
            if (last_addr) begin
              iss <= 1'b0;
            end else begin
              addr <= addr + AW'(1);
            end
          end else if (pass_done) begin
            if (bitpos == '0) begin
              thr   <= (x_final == '1) ? '0 : x_final;
              state <= S_EMIT;
              addr  <= '0;
              e_iss <= 1'b1;
            end else begin
              x      <= x_final;
              bitpos <= bitpos - BP_W'(1);
              addr   <= '0;
              iss    <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          // Read, clear and present one row at a time
          if (e_iss) begin
            e_iss <= 1'b0;
            e_v   <= 1'b1;
          end else if (e_v) begin
            out_row   <= lanes.keep;
            out_thr   <= thr;
            out_last  <= last_addr;
            out_valid <= 1'b1;
            e_v       <= 1'b0;
          end else if (out_xfer) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_LOAD;
            end else begin
              addr  <= addr + AW'(1);
              e_iss <= 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign row_ch.ready             = (state == S_LOAD);
  assign result_ch.valid          = out_valid;
  assign result_ch.out_row_pixels = out_row;
  assign result_ch.threshold_sq   = out_thr;
  assign result_ch.last_row       = out_last;

endmodule

/* rtl/core/rpnc_checker.sv */
// Port checker for the near-center pixel removal block, bound to the top level.
`timescale 1ns / 1ps
module rpnc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rpnc_pkg::ROW_W-1:0]  out_row,
  input logic [rpnc_pkg::DIST_W-1:0] out_thr,
  input logic                        out_last
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_thr))
    else $error("stalled result changed");

  // Never load rows while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("row input open while a result is shown");

  // Drop output after the final row transfers
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("output continued after last row");

  // Threshold stays within the reachable distance range
  a_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_thr <= rpnc_pkg::DIST_W'(rpnc_pkg::DIST_MAX))
    else $error("threshold out of range");

  // Reset clears the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind remove_pixels_nearest_center_top rpnc_checker u_rpnc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (row_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_row   (result_ch.out_row_pixels),
  .out_thr   (result_ch.threshold_sq),
  .out_last  (result_ch.last_row)
);
